// ----- design/mls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mls_pkg
// Shared widths, defaults and the result word type for the median block.
// ----------------------------------------------------------------------------
package mls_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int VALUE_W          = 16;
    localparam int MEDIAN_W         = 17;
    localparam int COUNT_W          = 7;

    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic signed [MEDIAN_W-1:0] median_t;

    typedef struct packed {
        logic                 valid;
        median_t              median_twice;
        logic [COUNT_W-1:0]   count;
        logic                 overflow;
    } mls_result_t;

endpackage

// ----- design/mls_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mls_ram
// Sorted value store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mls_ram #(
    parameter int DEPTH = mls_pkg::MAX_ELEMENTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  mls_pkg::value_t       wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output mls_pkg::value_t       rdata
);
    import mls_pkg::*;

    value_t mem [DEPTH];
    value_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/mls_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mls_core
// Insertion sequencer over the value store and median readout.
// ----------------------------------------------------------------------------
module mls_core #(
    parameter int MAX_ELEMENTS = mls_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mls_pkg::value_t      in_value,
    input  logic                 in_last,
    output mls_pkg::mls_result_t res,
    input  logic                 res_ready
);
    import mls_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_PLACE = 3'd2;
    localparam logic [2:0] ST_MRD0  = 3'd3;
    localparam logic [2:0] ST_MRD1  = 3'd4;
    localparam logic [2:0] ST_MRD2  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          drop_reg, drop_next;
    logic [AW-1:0] pos_reg, pos_next;
    value_t        v_reg, v_next;
    logic          last_reg, last_next;
    value_t        a_reg, a_next;
    median_t       med_reg, med_next;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    value_t        wdata, rdata;
    logic [CW-1:0] half;

    mls_ram #(.DEPTH(MAX_ELEMENTS), .AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign half = fill_reg >> 1;

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        drop_next  = drop_reg;
        pos_next   = pos_reg;
        v_next     = v_reg;
        last_next  = last_reg;
        a_next     = a_reg;
        med_next   = med_reg;
        we         = 1'b0;
        waddr      = pos_reg;
        wdata      = v_reg;
        re         = 1'b0;
        raddr      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    v_next    = in_value;
                    last_next = in_last;
                    if (fill_reg >= CW'(MAX_ELEMENTS)) begin
                        drop_next  = 1'b1;
                        state_next = in_last ? ST_MRD0 : ST_IDLE;
                    end else if (fill_reg == '0) begin
                        we         = 1'b1;
                        waddr      = '0;
                        wdata      = in_value;
                        fill_next  = fill_reg + 1'b1;
                        state_next = in_last ? ST_MRD0 : ST_IDLE;
                    end else begin
                        re         = 1'b1;
                        raddr      = AW'(fill_reg - 1'b1);
                        pos_next   = AW'(fill_reg);
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                we = 1'b1;
                if (rdata > v_reg) begin
                    wdata    = rdata;
                    pos_next = pos_reg - 1'b1;
                    if (pos_reg == AW'(1)) begin
                        state_next = ST_PLACE;
                    end else begin
                        re    = 1'b1;
                        raddr = pos_reg - AW'(2);
                    end
                end else begin
                    fill_next  = fill_reg + 1'b1;
                    state_next = last_reg ? ST_MRD0 : ST_IDLE;
                end
            end
            ST_PLACE: begin
                we         = 1'b1;
                fill_next  = fill_reg + 1'b1;
                state_next = last_reg ? ST_MRD0 : ST_IDLE;
            end
            ST_MRD0: begin
                if (fill_reg == '0) begin
                    med_next   = '0;
                    state_next = ST_OUT;
                end else begin
                    re         = 1'b1;
                    raddr      = fill_reg[0] ? AW'(half) : AW'(half - 1'b1);
                    state_next = ST_MRD1;
                end
            end
            ST_MRD1: begin
                if (fill_reg[0]) begin
                    med_next   = {rdata, 1'b0};
                    state_next = ST_OUT;
                end else begin
                    a_next     = rdata;
                    re         = 1'b1;
                    raddr      = AW'(half);
                    state_next = ST_MRD2;
                end
            end
            ST_MRD2: begin
                med_next   = {a_reg[VALUE_W-1], a_reg} + {rdata[VALUE_W-1], rdata};
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (res_ready) begin
                    fill_next  = '0;
                    drop_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            drop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        v_reg    <= v_next;
        last_reg <= last_next;
        a_reg    <= a_next;
        med_reg  <= med_next;
    end

    assign in_ready         = (state_reg == ST_IDLE);
    assign res.valid        = (state_reg == ST_OUT);
    assign res.median_twice = med_reg;
    assign res.count        = COUNT_W'(fill_reg);
    assign res.overflow     = drop_reg;

endmodule

// ----- design/median_of_loaded_set.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_of_loaded_set
// Median of a streamed set of signed values, kept sorted by insertion.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser     | tlast
//  s_      | in  | [15:0] value                   | -         | last of set
//  m_      | out | [16:0] median_twice, [23:17] count | [0] overflow | -
//
//  A value into n > 0 entries moves each larger entry up by one, read and written
//  through the value store; into an empty store it is written directly and into
//  a full one dropped. The last word then starts the median readout.
//  Reset clears the state, fill count and drop flag; the store is not cleared.
//  The result sits in an output register; the input stalls while a value is
//  inserted, in readout, and while a result cannot move into that register.
// ----------------------------------------------------------------------------
module median_of_loaded_set #(
    parameter int MAX_ELEMENTS = mls_pkg::MAX_ELEMENTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] median_twice, [23:17] count
    output logic [0:0]  m_tuser    // [0] overflow
);
    import mls_pkg::*;

    mls_result_t res;
    logic        res_ready;
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic        m_tuser_reg;

    mls_core #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .in_last   (s_tlast),
        .res       (res),
        .res_ready (res_ready)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res.valid) begin
            m_tdata_reg <= {res.count, res.median_twice};
            m_tuser_reg <= res.overflow;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !res.valid)
        else $error("input accepted while a result is pending");

    a_res_held: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && !res_ready |=> res.valid && $stable(res.median_twice))
        else $error("pending result changed before it was taken");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:17] != '0 || MAX_ELEMENTS >= 128)
        else $error("result with empty set");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[23:17] == COUNT_W'(MAX_ELEMENTS))
        else $error("overflow flagged without a full store");

endmodule

// ----- test/median_of_loaded_set_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_of_loaded_set_test
// Streams sets of signed values into the median block with random gaps and
// receiver stalls, computes each set's doubled median, count and drop flag
// alongside, and compares every result word field by field.
// ----------------------------------------------------------------------------
module median_of_loaded_set_test;
    import mls_pkg::*;

    localparam int CAPACITY     = MAX_ELEMENTS_DEF;
    localparam int RANDOM_WORDS = 650;
    localparam int HOLD_CYCLES  = 500;
    localparam int TAIL_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 4000;

    typedef struct packed {
        value_t value;
        logic   last;
    } word_t;

    typedef struct {
        median_t            median_twice;
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } median_rec_t;

    typedef enum int { VALS_FULL, VALS_NARROW, VALS_EXTREME } value_mix_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    median_of_loaded_set dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    word_t       send_queue[$];
    median_rec_t median_due[$];
    int          total_words  = 0;
    int          words_taken  = 0;
    int          results_seen = 0;
    int          errors       = 0;

    // running copy of the block's sorted store
    value_t sorted_vals[CAPACITY];
    int     kept    = 0;
    bit     dropped = 1'b0;

    task automatic note_error(input string msg);
        errors++;
        $display("ERROR t=%0t %s", $time, msg);
    endtask

    function automatic int idle_span(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic absorb_word(input word_t w);
        int          pos;
        int          twice;
        median_rec_t rec;
        if (kept >= CAPACITY) begin
            dropped = 1'b1;
        end else begin
            pos = kept;
            while (pos > 0 && sorted_vals[pos-1] > w.value) begin
                sorted_vals[pos] = sorted_vals[pos-1];
                pos--;
            end
            sorted_vals[pos] = w.value;
            kept++;
        end
        if (w.last) begin
            if (kept % 2 == 1)
                twice = 2 * int'(sorted_vals[kept/2]);
            else
                twice = int'(sorted_vals[kept/2-1]) + int'(sorted_vals[kept/2]);
            rec.median_twice = median_t'(twice);
            rec.count        = COUNT_W'(kept);
            rec.overflow     = dropped;
            median_due.push_back(rec);
            kept    = 0;
            dropped = 1'b0;
        end
    endtask

    // driver
    int gap_left = 0;
    always @(posedge aclk) begin
        word_t w;
        logic  next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                w.value = s_tdata;
                w.last  = s_tlast;
                absorb_word(w);
                words_taken++;
            end
            if (!s_tvalid || s_tready) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (send_queue.size() > 0) begin
                    w = send_queue.pop_front();
                    s_tdata    <= w.value;
                    s_tlast    <= w.last;
                    next_valid = 1'b1;
                    gap_left   = idle_span((words_taken / 50) % 5 == 2);
                end
                s_tvalid <= next_valid;
            end
        end
    end

    // monitor and receiver
    int hold_left  = 0;
    int ready_wait = 0;
    always @(posedge aclk) begin
        median_rec_t        want;
        median_t            got_med;
        logic [COUNT_W-1:0] got_cnt;
        logic               got_ovf;
        logic               next_ready;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_med = m_tdata[16:0];
                got_cnt = m_tdata[23:17];
                got_ovf = m_tuser[0];
                if (median_due.size() == 0) begin
                    note_error($sformatf("unexpected word: median_twice %0d count %0d ovf %0b",
                                         got_med, got_cnt, got_ovf));
                end else begin
                    want = median_due.pop_front();
                    if (got_med !== want.median_twice)
                        note_error($sformatf("word %0d median_twice %0d, want %0d",
                                             results_seen, got_med, want.median_twice));
                    if (got_cnt !== want.count)
                        note_error($sformatf("word %0d count %0d, want %0d",
                                             results_seen, got_cnt, want.count));
                    if (got_ovf !== want.overflow)
                        note_error($sformatf("word %0d overflow %0b, want %0b",
                                             results_seen, got_ovf, want.overflow));
                end
                results_seen++;
                if (results_seen == 20)
                    hold_left = HOLD_CYCLES;
                ready_wait = idle_span((results_seen / 6) % 5 == 2);
            end
            next_ready = 1'b1;
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (ready_wait > 0) begin
                ready_wait--;
                next_ready = 1'b0;
            end
            m_tready <= next_ready;
        end
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("ERROR t=%0t no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_word(input int v, input bit last);
        word_t w;
        w.value = value_t'(v);
        w.last  = last;
        send_queue.push_back(w);
        total_words++;
    endtask

    function automatic int random_value(input value_mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        if (mix == VALS_NARROW || (mix == VALS_FULL && r < 15))
            return $urandom_range(0, 6) - 3;
        if (mix == VALS_EXTREME || r < 25) begin
            case ($urandom_range(0, 3))
                0: return -32768;
                1: return -32767;
                2: return 32766;
                default: return 32767;
            endcase
        end
        return int'($signed(16'($urandom)));
    endfunction

    task automatic add_set(input int size);
        value_mix_t mix;
        int         r;
        r = $urandom_range(0, 9);
        mix = (r < 6) ? VALS_FULL : (r < 9) ? VALS_NARROW : VALS_EXTREME;
        for (int i = 0; i < size; i++)
            add_word(random_value(mix), i == size - 1);
    endtask

    initial begin
        int start_words;
        int r;

        // single extremes, paired extremes
        add_word(-32768, 1'b1);
        add_word(32767, 1'b1);
        add_word(32767, 1'b0);
        add_word(32767, 1'b1);
        add_word(-32768, 1'b0);
        add_word(-32768, 1'b1);
        // unordered odd set
        add_word(5, 1'b0);
        add_word(-3, 1'b0);
        add_word(0, 1'b1);
        // even set spanning full range
        add_word(32767, 1'b0);
        add_word(-32768, 1'b0);
        add_word(1, 1'b0);
        add_word(-1, 1'b1);
        // duplicates
        add_word(7, 1'b0);
        add_word(7, 1'b0);
        add_word(7, 1'b0);
        add_word(2, 1'b1);
        // odd-sum middle pair -> half LSB
        add_word(-2, 1'b0);
        add_word(1, 1'b1);

        start_words = total_words;
        add_set(CAPACITY + $urandom_range(1, 4));
        add_set(CAPACITY);
        while (total_words - start_words < RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                add_set($urandom_range(1, 8));
            else if (r < 88)
                add_set($urandom_range(9, 40));
            else
                add_set($urandom_range(CAPACITY - 8, CAPACITY + 8));
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (words_taken != total_words || median_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (median_due.size() != 0)
            note_error($sformatf("%0d results never arrived", median_due.size()));
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
design/mls_pkg.sv
design/mls_ram.sv
design/mls_core.sv
design/median_of_loaded_set.sv
test/median_of_loaded_set_test.sv
